// File: rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// Minute calendar clock package
// Shared widths, calendar constants, reciprocals, codes and queue word type.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 31;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;

  localparam int unsigned MIN_PER_HOUR    = 60;
  localparam int unsigned HOURS_PER_DAY   = 24;
  localparam int unsigned DAYS_PER_MONTH  = 31;
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned MIN_PER_DAY     = MIN_PER_HOUR * HOURS_PER_DAY;
  localparam int unsigned MIN_PER_MONTH   = MIN_PER_DAY * DAYS_PER_MONTH;
  localparam int unsigned MIN_PER_YEAR    = MIN_PER_MONTH * MONTHS_PER_YEAR;

  // reciprocal estimate is low by at most one; corrected afterwards
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned PROD_W      = COUNT_W + RECIP_SHIFT;
  localparam longint unsigned RECIP_HOUR  = (64'd1 << RECIP_SHIFT) / MIN_PER_HOUR;
  localparam longint unsigned RECIP_DAY   = (64'd1 << RECIP_SHIFT) / MIN_PER_DAY;
  localparam longint unsigned RECIP_MONTH = (64'd1 << RECIP_SHIFT) / MIN_PER_MONTH;
  localparam longint unsigned RECIP_YEAR  = (64'd1 << RECIP_SHIFT) / MIN_PER_YEAR;

  // widths of the total hour, day and month counts
  localparam int unsigned QH_W = 26;
  localparam int unsigned QD_W = 21;
  localparam int unsigned QM_W = 16;

  localparam int unsigned NIGHT_ABOVE     = 21;
  localparam int unsigned NIGHT_BELOW     = 4;
  localparam int unsigned EVENING_ABOVE   = 16;
  localparam int unsigned AFTERNOON_ABOVE = 8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_SET    = 2'd1,
    OP_ADD    = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_MORNING   = 2'd0,
    PH_AFTERNOON = 2'd1,
    PH_EVENING   = 2'd2,
    PH_NIGHT     = 2'd3
  } phase_e;

  typedef struct packed {
    op_e                op;
    logic               unit_step;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

// File: rtl/mcc_if.sv
// ----------------------------------------------------------------------------
// Minute calendar clock channels
// Valid/ready interfaces for the command word and the result word.
// ----------------------------------------------------------------------------
interface mcc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [mcc_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [mcc_pkg::COUNT_W-1:0]   total_time;
  logic [mcc_pkg::YEAR_W-1:0]    year;
  logic [mcc_pkg::MONTH_W-1:0]   month;
  logic [mcc_pkg::DAY_W-1:0]     day;
  logic [mcc_pkg::HOUR_W-1:0]    hour;
  logic [mcc_pkg::MINUTE_W-1:0]  minute;
  logic [1:0]                    day_phase;
  logic                          hour_changed;
  logic                          phase_changed;
  logic                          weather_check;
  logic                          error;

  modport source (output valid, output total_time, output year, output month, output day,
                  output hour, output minute, output day_phase, output hour_changed,
                  output phase_changed, output weather_check, output error, input ready);
  modport sink   (input valid, input total_time, input year, input month, input day,
                  input hour, input minute, input day_phase, input hour_changed,
                  input phase_changed, input weather_check, input error, output ready);
endinterface

// File: rtl/minute_calendar_clock_core.sv
// Path: an accepted word is written into the queue, then registered through stages 1, 2, 3 and the result register.
// Throughput: one word per cycle while the queue is not full, set by the front end's registered count update.
// The four-entry queue lets input words keep arriving while the result is stalled.
// Reset: count zero, day phase night, queue and pipeline empty.
// ----------------------------------------------------------------------------
// Minute calendar clock core
// Minute counter with a twelve-month, 31-day calendar breakdown and day phase.
// ----------------------------------------------------------------------------
module minute_calendar_clock_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcc_in_if.sink    in_i,
  mcc_out_if.source out_o
);
  import mcc_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;

  mcc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  mcc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  mcc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: rtl/mcc_fifo.sv
// ----------------------------------------------------------------------------
// Minute calendar clock command queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module mcc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcc_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output mcc_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import mcc_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, wptr_d;
  logic [FIFO_AW-1:0] rptr_q, rptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/mcc_front.sv
// ----------------------------------------------------------------------------
// Minute calendar clock front end
// Takes command words, updates the minute count and classifies each word.
// ----------------------------------------------------------------------------
module mcc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcc_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output mcc_pkg::cmd_t cmd_o
);
  import mcc_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d;
  logic [VALUE_W:0]   sum;
  logic               accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;

  // 33-bit signed sum; bit 32 set means negative, bit 31 means past the top
  assign sum = {2'b00, count_q} + {in_i.value[VALUE_W-1], in_i.value};

  always_comb begin
    cmd_o.unit_step = (in_i.value == VALUE_W'(1));
    cmd_o.op        = OP_HOLD;
    count_d         = count_q;
    if (in_i.mode) begin
      if (in_i.value[VALUE_W-1]) begin
        cmd_o.op = OP_REJECT;
      end else begin
        cmd_o.op = OP_SET;
        count_d  = in_i.value[COUNT_W-1:0];
      end
    end else if (in_i.value != '0) begin
      if (sum[VALUE_W] || sum[VALUE_W-1]) begin
        cmd_o.op = OP_REJECT;
      end else begin
        cmd_o.op = OP_ADD;
        count_d  = sum[COUNT_W-1:0];
      end
    end
    cmd_o.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

`ifndef SYNTH
  a_reject_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd_o.op == OP_REJECT) |=> (count_q == $past(count_q)))
    else $error("rejected word changed the minute count");
`endif

endmodule

// File: rtl/mcc_back.sv
// ----------------------------------------------------------------------------
// Minute calendar clock back end
// Splits the count into calendar fields, tracks the day phase, holds the result.
// ----------------------------------------------------------------------------
module mcc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  mcc_pkg::cmd_t cmd_i,
  output logic          pop_o,
  mcc_out_if.source     out_o
);
  import mcc_pkg::*;

  function automatic phase_e phase_of(input logic [HOUR_W-1:0] h);
    phase_e p;
    if (h > HOUR_W'(NIGHT_ABOVE) || h < HOUR_W'(NIGHT_BELOW)) begin
      p = PH_NIGHT;
    end else if (h > HOUR_W'(EVENING_ABOVE)) begin
      p = PH_EVENING;
    end else if (h > HOUR_W'(AFTERNOON_ABOVE)) begin
      p = PH_AFTERNOON;
    end else begin
      p = PH_MORNING;
    end
    return p;
  endfunction

  logic en;

  // stage 1: reciprocal estimates
  logic               s1_valid_q;
  cmd_t               s1_cmd_q;
  logic [QH_W-1:0]    s1_qh_q, s1_qh_d;
  logic [QD_W-1:0]    s1_qd_q, s1_qd_d;
  logic [QM_W-1:0]    s1_qm_q, s1_qm_d;
  logic [YEAR_W-1:0]  s1_qy_q, s1_qy_d;
  logic [PROD_W-1:0]  ph, pd, pm, py;

  // stage 2: back products
  logic               s2_valid_q;
  cmd_t               s2_cmd_q;
  logic [QH_W-1:0]    s2_qh_q;
  logic [QD_W-1:0]    s2_qd_q;
  logic [QM_W-1:0]    s2_qm_q;
  logic [YEAR_W-1:0]  s2_qy_q;
  logic [COUNT_W-1:0] s2_bh_q, s2_bd_q, s2_bm_q, s2_by_q;

  // stage 3: exact quotients
  logic               s3_valid_q;
  cmd_t               s3_cmd_q;
  logic [QH_W-1:0]    s3_qh_q, s3_qh_d;
  logic [QD_W-1:0]    s3_qd_q, s3_qd_d;
  logic [QM_W-1:0]    s3_qm_q, s3_qm_d;
  logic [YEAR_W-1:0]  s3_qy_q, s3_qy_d;
  logic [MINUTE_W-1:0] s3_min_q, s3_min_d;
  logic [COUNT_W-1:0] rh, rd, rm, ry;

  // result
  logic               out_valid_q;
  phase_e             phase_q, phase_d;
  logic [HOUR_W-1:0]  hour_d;
  logic [DAY_W-1:0]   day_d;
  logic [MONTH_W-1:0] month_d;
  phase_e             ph_new;
  logic               hc_d, pc_d, wc_d;
  logic [COUNT_W-1:0] tot_q;
  logic [YEAR_W-1:0]  year_q;
  logic [MONTH_W-1:0] month_q;
  logic [DAY_W-1:0]   day_q;
  logic [HOUR_W-1:0]  hour_q;
  logic [MINUTE_W-1:0] min_q;
  logic               hc_q, pc_q, wc_q, err_q;

  assign en    = !out_valid_q || out_o.ready;
  assign pop_o = en && !empty_i;

  always_comb begin
    ph      = PROD_W'(cmd_i.count) * PROD_W'(RECIP_HOUR);
    pd      = PROD_W'(cmd_i.count) * PROD_W'(RECIP_DAY);
    pm      = PROD_W'(cmd_i.count) * PROD_W'(RECIP_MONTH);
    py      = PROD_W'(cmd_i.count) * PROD_W'(RECIP_YEAR);
    s1_qh_d = QH_W'(ph >> RECIP_SHIFT);
    s1_qd_d = QD_W'(pd >> RECIP_SHIFT);
    s1_qm_d = QM_W'(pm >> RECIP_SHIFT);
    s1_qy_d = YEAR_W'(py >> RECIP_SHIFT);
  end

  always_comb begin
    rh = s2_cmd_q.count - s2_bh_q;
    rd = s2_cmd_q.count - s2_bd_q;
    rm = s2_cmd_q.count - s2_bm_q;
    ry = s2_cmd_q.count - s2_by_q;
    s3_qh_d  = s2_qh_q;
    s3_min_d = MINUTE_W'(rh);
    if (rh >= COUNT_W'(MIN_PER_HOUR)) begin
      s3_qh_d  = s2_qh_q + 1'b1;
      s3_min_d = MINUTE_W'(rh - COUNT_W'(MIN_PER_HOUR));
    end
    s3_qd_d = (rd >= COUNT_W'(MIN_PER_DAY))   ? s2_qd_q + 1'b1 : s2_qd_q;
    s3_qm_d = (rm >= COUNT_W'(MIN_PER_MONTH)) ? s2_qm_q + 1'b1 : s2_qm_q;
    s3_qy_d = (ry >= COUNT_W'(MIN_PER_YEAR))  ? s2_qy_q + 1'b1 : s2_qy_q;
  end

  // remainders are small, so only the low bits of the quotients matter
  always_comb begin
    hour_d  = s3_qh_q[HOUR_W-1:0]
            - HOUR_W'(s3_qd_q[HOUR_W-1:0] * HOUR_W'(HOURS_PER_DAY));
    day_d   = s3_qd_q[DAY_W-1:0]
            - DAY_W'(s3_qm_q[DAY_W-1:0] * DAY_W'(DAYS_PER_MONTH)) + 1'b1;
    month_d = s3_qm_q[MONTH_W-1:0]
            - MONTH_W'(s3_qy_q[MONTH_W-1:0] * MONTH_W'(MONTHS_PER_YEAR)) + 1'b1;
    ph_new  = phase_of(hour_d);
    hc_d    = (s3_cmd_q.op == OP_ADD) && (s3_min_q == '0);
    pc_d    = hc_d && (ph_new != phase_q);
    wc_d    = pc_d && s3_cmd_q.unit_step;
    phase_d = phase_q;
    if (s3_cmd_q.op == OP_SET || pc_d) begin
      phase_d = ph_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_NIGHT;
    end else if (en) begin
      s1_valid_q  <= !empty_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
      if (s3_valid_q) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q <= cmd_i;
      s1_qh_q  <= s1_qh_d;
      s1_qd_q  <= s1_qd_d;
      s1_qm_q  <= s1_qm_d;
      s1_qy_q  <= s1_qy_d;
      s2_cmd_q <= s1_cmd_q;
      s2_qh_q  <= s1_qh_q;
      s2_qd_q  <= s1_qd_q;
      s2_qm_q  <= s1_qm_q;
      s2_qy_q  <= s1_qy_q;
      s2_bh_q  <= COUNT_W'(s1_qh_q) * COUNT_W'(MIN_PER_HOUR);
      s2_bd_q  <= COUNT_W'(s1_qd_q) * COUNT_W'(MIN_PER_DAY);
      s2_bm_q  <= COUNT_W'(s1_qm_q) * COUNT_W'(MIN_PER_MONTH);
      s2_by_q  <= COUNT_W'(s1_qy_q) * COUNT_W'(MIN_PER_YEAR);
      s3_cmd_q <= s2_cmd_q;
      s3_qh_q  <= s3_qh_d;
      s3_qd_q  <= s3_qd_d;
      s3_qm_q  <= s3_qm_d;
      s3_qy_q  <= s3_qy_d;
      s3_min_q <= s3_min_d;
      tot_q    <= s3_cmd_q.count;
      year_q   <= s3_qy_q;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      min_q    <= s3_min_q;
      hc_q     <= hc_d;
      pc_q     <= pc_d;
      wc_q     <= wc_d;
      err_q    <= (s3_cmd_q.op == OP_REJECT);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.total_time    = tot_q;
  assign out_o.year          = year_q;
  assign out_o.month         = month_q;
  assign out_o.day           = day_q;
  assign out_o.hour          = hour_q;
  assign out_o.minute        = min_q;
  assign out_o.day_phase     = phase_q;
  assign out_o.hour_changed  = hc_q;
  assign out_o.phase_changed = pc_q;
  assign out_o.weather_check = wc_q;
  assign out_o.error         = err_q;

`ifndef SYNTH
  a_err_no_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error) |-> !(out_o.hour_changed || out_o.phase_changed))
    else $error("event flagged on a rejected word");
  a_weather_needs_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.weather_check) |-> (out_o.phase_changed && out_o.hour_changed))
    else $error("weather check without a phase change");
  a_hour_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.hour_changed) |-> (out_o.minute == '0))
    else $error("hour event off minute zero");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Minute calendar clock testbench
// Drives add and set words into the clock core with bursty traffic against a
// stalling receiver. A scoreboard holds its own minute count and day phase,
// predicts every result word and checks each one field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mcc_pkg::*;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_SET = 1'b1;
  localparam longint COUNT_MAX = (64'd1 << COUNT_W) - 1;
  localparam int unsigned LATENCY = 4;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_WORDS = 1725;

  typedef struct packed {
    logic [COUNT_W-1:0]  total_time;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [1:0]          day_phase;
    logic                hour_changed;
    logic                phase_changed;
    logic                weather_check;
    logic                error;
  } clock_word_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LIGHT, RX_PULSE} rx_style_e;

  class clock_scoreboard;
    logic [COUNT_W-1:0] count;
    phase_e             phase;
    clock_word_t        expected_q[$];
    int unsigned        failures;

    function new();
      count = '0;
      phase = PH_NIGHT;
      failures = 0;
    endfunction

    function phase_e phase_for(input logic [COUNT_W-1:0] c);
      int unsigned h;
      h = (c % MIN_PER_DAY) / MIN_PER_HOUR;
      if (h > NIGHT_ABOVE || h < NIGHT_BELOW) return PH_NIGHT;
      if (h > EVENING_ABOVE) return PH_EVENING;
      if (h > AFTERNOON_ABOVE) return PH_AFTERNOON;
      return PH_MORNING;
    endfunction

    function string describe(input clock_word_t w);
      return $sformatf("t=%0d y=%0d mo=%0d d=%0d %0d:%0d ph=%0d hc=%b pc=%b wc=%b err=%b",
                       w.total_time, w.year, w.month, w.day, w.hour, w.minute,
                       w.day_phase, w.hour_changed, w.phase_changed, w.weather_check,
                       w.error);
    endfunction

    function void note_command(input logic mode, input logic [VALUE_W-1:0] value);
      clock_word_t w;
      longint      delta;
      longint      sum;
      phase_e      np;
      w = '0;
      delta = longint'($signed(value));
      if (mode == MODE_SET) begin
        if (delta < 0) begin
          w.error = 1'b1;
        end else begin
          count = value[COUNT_W-1:0];
          phase = phase_for(count);
        end
      end else if (delta != 0) begin
        sum = longint'(count) + delta;
        if (sum < 0 || sum > COUNT_MAX) begin
          w.error = 1'b1;
        end else begin
          count = sum[COUNT_W-1:0];
          if (count % MIN_PER_HOUR == 0) begin
            np = phase_for(count);
            w.hour_changed = 1'b1;
            if (np != phase) begin
              phase = np;
              w.phase_changed = 1'b1;
              w.weather_check = (delta == 1);
            end
          end
        end
      end
      w.total_time = count;
      w.year       = count / MIN_PER_YEAR;
      w.month      = (count % MIN_PER_YEAR) / MIN_PER_MONTH + 1;
      w.day        = (count % MIN_PER_MONTH) / MIN_PER_DAY + 1;
      w.hour       = (count % MIN_PER_DAY) / MIN_PER_HOUR;
      w.minute     = count % MIN_PER_HOUR;
      w.day_phase  = phase;
      expected_q.push_back(w);
    endfunction

    function void check_result(input clock_word_t got);
      clock_word_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected result word: %s", $time, describe(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.total_time !== want.total_time || got.year !== want.year ||
          got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute ||
          got.day_phase !== want.day_phase || got.hour_changed !== want.hour_changed ||
          got.phase_changed !== want.phase_changed ||
          got.weather_check !== want.weather_check || got.error !== want.error) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("%0t: result mismatch", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  mcc_in_if  in_bus ();
  mcc_out_if out_bus ();

  minute_calendar_clock_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  clock_scoreboard sb;
  int unsigned     idle_cycles;
  int unsigned     burst_left;
  int unsigned     rx_left;
  rx_style_e       rx_style;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: ready pattern changes to a random style each time its run counter runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 300);
    end else begin
      rx_left--;
    end
    case (rx_style)
      RX_OPEN:  out_bus.ready <= 1'b1;
      RX_COIN:  out_bus.ready <= $urandom_range(0, 1);
      RX_LIGHT: out_bus.ready <= ($urandom_range(0, 9) != 0);
      default:  out_bus.ready <= ((rx_left % 23) < 5);
    endcase
  end

  always @(posedge clk) begin
    clock_word_t got;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        sb.note_command(in_bus.mode, in_bus.value);
      if (out_bus.valid && out_bus.ready) begin
        got.total_time    = out_bus.total_time;
        got.year          = out_bus.year;
        got.month         = out_bus.month;
        got.day           = out_bus.day;
        got.hour          = out_bus.hour;
        got.minute        = out_bus.minute;
        got.day_phase     = out_bus.day_phase;
        got.hour_changed  = out_bus.hour_changed;
        got.phase_changed = out_bus.phase_changed;
        got.weather_check = out_bus.weather_check;
        got.error         = out_bus.error;
        sb.check_result(got);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // called just after a falling edge; holds the word until it is taken
  task automatic present_word(input logic mode, input logic [VALUE_W-1:0] value);
    in_bus.valid <= 1'b1;
    in_bus.mode  <= mode;
    in_bus.value <= value;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic next_slot();
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 30);
      repeat (gap) begin
        in_bus.valid <= 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_word(input logic mode, input logic [VALUE_W-1:0] value);
    next_slot();
    present_word(mode, value);
  endtask

  task automatic send_random_word();
    int unsigned r;
    longint      step;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      present_word(MODE_ADD, 32'd1);
    end else if (r < 45) begin
      step = MIN_PER_HOUR - (sb.count % MIN_PER_HOUR) + MIN_PER_HOUR * $urandom_range(0, 30);
      present_word(MODE_ADD, step[VALUE_W-1:0]);
    end else if (r < 52) begin
      step = -longint'(sb.count % MIN_PER_HOUR) - MIN_PER_HOUR * $urandom_range(0, 5);
      present_word(MODE_ADD, step[VALUE_W-1:0]);
    end else if (r < 60) begin
      step = longint'($urandom_range(0, 10000)) - 5000;
      present_word(MODE_ADD, step[VALUE_W-1:0]);
    end else if (r < 70) begin
      present_word(MODE_SET, $urandom_range(0, 3 * MIN_PER_YEAR));
    end else if (r < 75) begin
      present_word(MODE_SET, $urandom_range(0, 100000) * MIN_PER_HOUR + MIN_PER_HOUR - 1);
    end else if (r < 80) begin
      present_word(MODE_SET, $urandom);
    end else if (r < 85) begin
      present_word(MODE_ADD, $urandom);
    end else if (r < 90) begin
      present_word(MODE_ADD, '0);
    end else if (r < 95) begin
      step = COUNT_MAX - $urandom_range(0, 3000);
      present_word(MODE_SET, step[VALUE_W-1:0]);
    end else begin
      present_word(MODE_ADD, $urandom >> 1);
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    burst_left = 0;
    rx_left = 0;
    rx_style = RX_OPEN;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_ADD;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: holds, rejections, limits, phase edges, calendar rollover
    send_word(MODE_ADD, 32'd0);
    send_word(MODE_ADD, 32'd1);
    send_word(MODE_ADD, 32'hFFFF_FFFF);
    send_word(MODE_ADD, 32'hFFFF_FFFF);
    send_word(MODE_SET, 32'hFFFF_FFFF);
    send_word(MODE_SET, 32'h8000_0000);
    send_word(MODE_SET, 32'h7FFF_FFFF);
    send_word(MODE_ADD, 32'd1);
    send_word(MODE_ADD, 32'h8000_0000);
    send_word(MODE_SET, 32'd239);
    send_word(MODE_ADD, 32'd1);
    send_word(MODE_ADD, 32'd60);
    send_word(MODE_SET, 32'd539);
    send_word(MODE_ADD, 32'd1);
    send_word(MODE_SET, 32'd1019);
    send_word(MODE_ADD, 32'd1);
    send_word(MODE_SET, 32'd1319);
    send_word(MODE_ADD, 32'd1);
    send_word(MODE_SET, 32'd1380);
    send_word(MODE_ADD, 32'd60);
    send_word(MODE_ADD, 32'd480);
    send_word(MODE_ADD, 32'h7FFF_FFFF);
    send_word(MODE_SET, MIN_PER_YEAR - 1);
    send_word(MODE_ADD, 32'd1);
    send_word(MODE_SET, MIN_PER_MONTH - 1);
    send_word(MODE_ADD, 32'd1);

    repeat (RANDOM_WORDS) begin
      next_slot();
      send_random_word();
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
